@@ sv/gup_pkg.sv @@
// gup_pkg: shared constants, types and codes for the 2x bilinear grid upsampler.
// Used by every module of the block; depends on nothing.
`default_nettype none

package gup_pkg;

	localparam int MAX_GRID  = 256;
	localparam int ADDR_W    = $clog2(MAX_GRID);
	localparam int COORD_W   = ADDR_W + 1;
	localparam int SAMPLE_W  = 16;
	localparam int GRID_W    = 9;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int SLOTS     = 9;
	localparam int SLOT_W    = $clog2(SLOTS);

	localparam logic [GRID_W-1:0]      GRID_RESET    = GRID_W'(16);
	localparam logic [PADDR_W-3:0]     REG_GRID_SIZE = '0;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic [1:0] {
		K_CORNER = 2'd0,
		K_TOP    = 2'd1,
		K_LEFT   = 2'd2,
		K_INNER  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		M_COPY = 2'd0,
		M_MIX  = 2'd1,
		M_QUAD = 2'd2
	} mode_t;

	typedef struct packed {
		kind_t             kind;
		logic              lastr;
		logic              lastc;
		logic [ADDR_W-1:0] r;
		logic [ADDR_W-1:0] c;
		sample_t           s;
		sample_t           u;
		sample_t           l;
		sample_t           ul;
	} job_t;

endpackage

`default_nettype wire

@@ sv/gup_ifs.sv @@
// gup_ifs: valid/ready channel interfaces for input samples and output results.
// Depends on gup_pkg for field widths.
`default_nettype none

interface gup_sample_if
	import gup_pkg::*;
();
	logic    valid;
	logic    ready;
	sample_t sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface gup_result_if
	import gup_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] out_row;
	logic [COORD_W-1:0] out_col;
	sample_t            out_value;
	logic               run_last;

	modport source (output valid, output out_row, output out_col, output out_value,
		output run_last, input ready);
	modport sink (input valid, input out_row, input out_col, input out_value,
		input run_last, output ready);
endinterface

`default_nettype wire

@@ sv/gup_front.sv @@
// gup_front: accepts samples, tracks grid position, keeps the line store and
// neighbors, and pushes one classified job per sample. Depends on gup_pkg, gup_ifs.
`default_nettype none

module gup_front
	import gup_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              restart,
	input  wire logic [ADDR_W-1:0] side_m1,
	gup_sample_if.sink             samples,
	output      logic              push_valid,
	input  wire logic              push_ready,
	output      job_t              push_data
);

	sample_t           line_mem [MAX_GRID];
	sample_t           rd_q;
	sample_t           left_q;
	sample_t           ul_q;
	logic [ADDR_W-1:0] r_q;
	logic [ADDR_W-1:0] c_q;
	logic              v_s1;
	sample_t           s_s1;
	sample_t           l_s1;
	logic [ADDR_W-1:0] r_s1;
	logic [ADDR_W-1:0] c_s1;
	logic              lastr_s1;
	logic              lastc_s1;
	logic              take;
	sample_t           u_eff;

	assign samples.ready = !v_s1 || push_ready;
	assign take          = samples.valid && samples.ready;
	assign push_valid    = v_s1;
	assign u_eff         = (r_s1 != '0) ? rd_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			r_q  <= '0;
			c_q  <= '0;
		end else begin
			if (take) begin
				v_s1 <= 1'b1;
			end else if (push_ready) begin
				v_s1 <= 1'b0;
			end
			if (restart) begin
				r_q <= '0;
				c_q <= '0;
			end else if (take) begin
				if (c_q == side_m1) begin
					c_q <= '0;
					r_q <= (r_q == side_m1) ? '0 : r_q + 1'b1;
				end else begin
					c_q <= c_q + 1'b1;
				end
			end
		end
	end

	// line store: read old entry, write new sample at the same column
	always_ff @(posedge clk) begin
		if (take) begin
			rd_q          <= line_mem[c_q];
			line_mem[c_q] <= samples.sample_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			s_s1     <= samples.sample_in;
			l_s1     <= left_q;
			r_s1     <= r_q;
			c_s1     <= c_q;
			lastr_s1 <= (r_q == side_m1);
			lastc_s1 <= (c_q == side_m1);
			left_q   <= samples.sample_in;
		end
		if (v_s1 && push_ready) begin
			ul_q <= u_eff;
		end
	end

	always_comb begin
		push_data       = '0;
		push_data.lastr = lastr_s1;
		push_data.lastc = lastc_s1;
		push_data.r     = r_s1;
		push_data.c     = c_s1;
		push_data.s     = s_s1;
		push_data.u     = u_eff;
		push_data.l     = l_s1;
		push_data.ul    = ul_q;
		if (r_s1 == '0) begin
			push_data.kind = (c_s1 == '0) ? K_CORNER : K_TOP;
		end else begin
			push_data.kind = (c_s1 == '0) ? K_LEFT : K_INNER;
		end
	end

endmodule

`default_nettype wire

@@ sv/gup_queue.sv @@
// gup_queue: short job queue between front and back of the upsampler.
// Depends on gup_pkg for the job type and depth.
`default_nettype none

module gup_queue
	import gup_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output      logic push_ready,
	input  wire job_t push_data,
	output      logic pop_valid,
	input  wire logic pop_ready,
	output      job_t pop_data
);

	job_t              slots_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              push;
	logic              pop;

	assign push_ready = cnt_q != (QPTR_W+1)'(QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = slots_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

@@ sv/gup_back.sv @@
// gup_back: expands each job into its output samples, one per cycle when
// unstalled, through a registered output stage. Depends on gup_pkg, gup_ifs.
`default_nettype none

module gup_back
	import gup_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [ADDR_W-1:0] side_m1,
	input  wire logic              pop_valid,
	output      logic              pop_ready,
	input  wire job_t              pop_data,
	gup_result_if.source           results
);

	job_t               job_q;
	logic               job_v_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               ov_q;
	logic [COORD_W-1:0] row_q;
	logic [COORD_W-1:0] col_q;
	sample_t            val_q;
	logic               last_q;

	logic [SLOTS-1:0]   mask;
	logic [SLOTS-1:0]   rem;
	logic [SLOT_W-1:0]  nxt;
	logic               last;
	logic               out_load;
	logic               emit;
	logic [COORD_W-1:0] y_c;
	logic [COORD_W-1:0] r2;
	logic [COORD_W-1:0] r2m1;
	logic [COORD_W-1:0] c2;
	logic [COORD_W-1:0] c2m1;
	logic [COORD_W-1:0] row_n;
	logic [COORD_W-1:0] col_n;
	mode_t              mode;
	sample_t            ma, mb, qa, qb, qc, qd;
	sample_t            val_n;

	function automatic sample_t mix4(input sample_t a, input sample_t b);
		logic signed [SAMPLE_W+2:0] t;
		t = ((SAMPLE_W+3)'(a) <<< 1) + (SAMPLE_W+3)'(a) + (SAMPLE_W+3)'(b)
			+ (SAMPLE_W+3)'(2);
		return SAMPLE_W'(t >>> 2);
	endfunction

	function automatic sample_t quad(input sample_t a, input sample_t b,
			input sample_t c, input sample_t d);
		logic signed [SAMPLE_W+4:0] t;
		t = ((SAMPLE_W+5)'(a) <<< 3) + (SAMPLE_W+5)'(a)
			+ ((SAMPLE_W+5)'(b) <<< 1) + (SAMPLE_W+5)'(b)
			+ ((SAMPLE_W+5)'(c) <<< 1) + (SAMPLE_W+5)'(c)
			+ (SAMPLE_W+5)'(d) + (SAMPLE_W+5)'(8);
		return SAMPLE_W'(t >>> 4);
	endfunction

	assign y_c  = {side_m1, 1'b1};
	assign r2   = {job_q.r, 1'b0};
	assign r2m1 = r2 - 1'b1;
	assign c2   = {job_q.c, 1'b0};
	assign c2m1 = c2 - 1'b1;

	always_comb begin
		case (job_q.kind)
			K_CORNER: mask = SLOTS'(1);
			K_TOP:    mask = {6'b0, job_q.lastc, 2'b11};
			K_LEFT:   mask = {6'b0, job_q.lastr, 2'b11};
			K_INNER:  mask = {job_q.lastr && job_q.lastc, job_q.lastr, job_q.lastr,
				job_q.lastc, 2'b11, job_q.lastc, 2'b11};
			default:  mask = SLOTS'(1);
		endcase
	end

	assign rem = mask & ~((SLOTS'(2) << slot_q) - 1'b1);
	assign last = rem == '0;

	always_comb begin
		nxt = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (rem[i]) begin
				nxt = SLOT_W'(i);
			end
		end
	end

	// select coordinates and operands for the current slot
	always_comb begin
		row_n = '0;
		col_n = '0;
		mode  = M_COPY;
		ma    = job_q.s;
		mb    = job_q.s;
		qa    = job_q.ul;
		qb    = job_q.l;
		qc    = job_q.u;
		qd    = job_q.s;
		case (job_q.kind)
			K_CORNER: begin
				row_n = '0;
				col_n = '0;
			end
			K_TOP: begin
				row_n = '0;
				case (slot_q)
					SLOT_W'(0): begin col_n = c2m1; mode = M_MIX; ma = job_q.l; end
					SLOT_W'(1): begin col_n = c2;   mode = M_MIX; mb = job_q.l; end
					default:    col_n = y_c;
				endcase
			end
			K_LEFT: begin
				col_n = '0;
				case (slot_q)
					SLOT_W'(0): begin row_n = r2m1; mode = M_MIX; ma = job_q.u; end
					SLOT_W'(1): begin row_n = r2;   mode = M_MIX; mb = job_q.u; end
					default:    row_n = y_c;
				endcase
			end
			K_INNER: begin
				case (slot_q)
					SLOT_W'(0): begin
						row_n = r2m1; col_n = c2m1; mode = M_QUAD;
					end
					SLOT_W'(1): begin
						row_n = r2m1; col_n = c2; mode = M_QUAD;
						qa = job_q.u; qb = job_q.ul; qc = job_q.s; qd = job_q.l;
					end
					SLOT_W'(2): begin
						row_n = r2m1; col_n = y_c; mode = M_MIX; ma = job_q.u;
					end
					SLOT_W'(3): begin
						row_n = r2; col_n = c2m1; mode = M_QUAD;
						qa = job_q.l; qb = job_q.ul; qc = job_q.s; qd = job_q.u;
					end
					SLOT_W'(4): begin
						row_n = r2; col_n = c2; mode = M_QUAD;
						qa = job_q.s; qb = job_q.l; qc = job_q.u; qd = job_q.ul;
					end
					SLOT_W'(5): begin
						row_n = r2; col_n = y_c; mode = M_MIX; mb = job_q.u;
					end
					SLOT_W'(6): begin
						row_n = y_c; col_n = c2m1; mode = M_MIX; ma = job_q.l;
					end
					SLOT_W'(7): begin
						row_n = y_c; col_n = c2; mode = M_MIX; mb = job_q.l;
					end
					default: begin
						row_n = y_c; col_n = y_c;
					end
				endcase
			end
			default: begin
				row_n = '0;
				col_n = '0;
			end
		endcase
	end

	always_comb begin
		case (mode)
			M_MIX:   val_n = mix4(ma, mb);
			M_QUAD:  val_n = quad(qa, qb, qc, qd);
			default: val_n = job_q.s;
		endcase
	end

	assign out_load  = !ov_q || results.ready;
	assign emit      = job_v_q && out_load;
	assign pop_ready = !job_v_q || (emit && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_v_q <= 1'b0;
			slot_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (pop_valid && pop_ready) begin
				job_v_q <= 1'b1;
				slot_q  <= '0;
			end else if (emit && last) begin
				job_v_q <= 1'b0;
				slot_q  <= '0;
			end else if (emit) begin
				slot_q <= nxt;
			end
			if (out_load) begin
				ov_q <= job_v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			job_q <= pop_data;
		end
		if (emit) begin
			row_q  <= row_n;
			col_q  <= col_n;
			val_q  <= val_n;
			last_q <= last;
		end
	end

	assign results.valid     = ov_q;
	assign results.out_row   = row_q;
	assign results.out_col   = col_q;
	assign results.out_value = val_q;
	assign results.run_last  = last_q;

	a_idle_slot: assert property (@(posedge clk) disable iff (!arst_n)
		!job_v_q |-> slot_q == '0)
		else $error("slot counter moved without a job");

	a_slot_live: assert property (@(posedge clk) disable iff (!arst_n)
		job_v_q |-> mask[slot_q])
		else $error("current slot not part of the job");

	a_last_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		emit && last |=> slot_q == '0)
		else $error("slot counter not rewound after final item");

	a_pop_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid && pop_ready && job_v_q |-> emit && last)
		else $error("job replaced before all its items left");

endmodule

`default_nettype wire

@@ sv/grid_upsample_2x_bilinear_core.sv @@
// Each sample passes the front register, job queue, job register and output register.
// Throughput: one result per cycle on the output channel while it is ready and
// jobs are queued; each sample gives 1 to 9 results (4 on average for large grids).
// A 4-job queue separates sample intake from result generation.
// Reset: grid position to (0,0), grid_size to 16; the line store is not cleared.
// Depends on gup_pkg, gup_ifs, gup_front, gup_queue, gup_back.
`default_nettype none

module grid_upsample_2x_bilinear_core
	import gup_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output      logic [PDATA_W-1:0] prdata,
	output      logic               pready,
	gup_sample_if.sink              samples,
	gup_result_if.source            results
);

	logic [GRID_W-1:0] grid_size_q;
	logic [ADDR_W-1:0] side_m1;
	logic              reg_hit;
	logic              cfg_wr;
	logic              q_push_valid;
	logic              q_push_ready;
	job_t              q_push_data;
	logic              q_pop_valid;
	logic              q_pop_ready;
	job_t              q_pop_data;

	assign pready  = 1'b1;
	assign reg_hit = paddr[PADDR_W-1:2] == REG_GRID_SIZE;
	assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? PDATA_W'(grid_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= GRID_RESET;
		end else if (cfg_wr) begin
			grid_size_q <= pwdata[GRID_W-1:0];
		end
	end

	// clamp side length to 2..MAX_GRID, keep side minus one
	always_comb begin
		if (grid_size_q < GRID_W'(2)) begin
			side_m1 = ADDR_W'(1);
		end else if (grid_size_q > GRID_W'(MAX_GRID)) begin
			side_m1 = ADDR_W'(MAX_GRID - 1);
		end else begin
			side_m1 = ADDR_W'(grid_size_q - 1'b1);
		end
	end

	gup_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (cfg_wr),
		.side_m1    (side_m1),
		.samples    (samples),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data)
	);

	gup_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_data   (q_pop_data)
	);

	gup_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.side_m1   (side_m1),
		.pop_valid (q_pop_valid),
		.pop_ready (q_pop_ready),
		.pop_data  (q_pop_data),
		.results   (results)
	);

endmodule

`default_nettype wire
